// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the DNS record parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define DRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside of reset.
`define DRP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// drp_pkg
// Word types, event codes and sizing constants of the DNS record parser.
// ----------------------------------------------------------------------------
package drp_pkg;

  // Event kinds
  localparam logic [2:0] EV_HEADER    = 3'd0;
  localparam logic [2:0] EV_QUESTION  = 3'd1;
  localparam logic [2:0] EV_RECORD    = 3'd2;
  localparam logic [2:0] EV_TRUNCATED = 3'd3;
  localparam logic [2:0] EV_END       = 3'd4;

  // Compression pointer marker bits of a label length byte
  localparam logic [7:0] PTR_MASK = 8'hc0;

  // Default depth of the event queue
  localparam int EVQ_DEPTH = 4;

  // One message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } octet_t;

  // One parse event
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  section;
    logic [15:0] message_ident;
    logic [15:0] header_flags;
    logic [15:0] rr_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
    logic [7:0]  name_bytes;
    logic        name_compressed;
    logic        last;
  } event_t;

  // Push request from the parser into the event queue (second implies first)
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== src/drp_parser.sv =====
// ----------------------------------------------------------------------------
// drp_parser
// Byte-wide DNS message parser: updates parse state for each accepted byte
// and issues up to two events for it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  drp_pkg::octet_t octet,
  output drp_pkg::push_t  push,
  output drp_pkg::event_t slot0,
  output drp_pkg::event_t slot1
);
  import drp_pkg::*;

  // Parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_PTR2   = 3'd3;
  localparam logic [2:0] PH_FIXED  = 3'd4;
  localparam logic [2:0] PH_RDATA  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  typedef struct packed {
    logic        done;
    logic [1:0]  sec;
    logic [15:0] items;
  } seek_t;

  // Parse state
  logic [2:0]        phase, phase_next;
  logic [3:0]        idx, idx_next;
  logic [3:0][15:0]  counts, counts_next;
  logic [1:0]        cur_sec, cur_sec_next;
  logic [15:0]       items, items_next;
  logic [7:0]        label_left, label_left_next;
  logic [15:0]       rdata_left, rdata_left_next;
  logic [31:0]       shift, shift_next;
  logic [15:0]       held_ident, held_ident_next;
  logic [15:0]       held_flags, held_flags_next;
  logic [15:0]       held_type, held_type_next;
  logic [15:0]       held_class, held_class_next;
  logic [7:0]        held_nb, held_nb_next;
  logic              held_comp, held_comp_next;

  // Skip empty sections, starting from section s with il items left
  function automatic seek_t seek(input logic [1:0] s, input logic [15:0] il,
                                 input logic [3:0][15:0] cnt);
    seek_t r;
    r.done  = 1'b0;
    r.sec   = s;
    r.items = il;
    for (int i = 0; i < 4; i++) begin
      if (r.items == 16'd0 && !r.done) begin
        if (r.sec == 2'd3) begin
          r.done = 1'b1;
        end else begin
          r.sec   = r.sec + 2'd1;
          r.items = cnt[r.sec];
        end
      end
    end
    return r;
  endfunction

  logic [7:0]  b;
  logic        eop;
  logic        seek_go;
  logic [1:0]  seek_sec;
  logic [15:0] seek_items;
  seek_t       sk;
  logic        done;
  logic        stop;
  logic        ev0_valid, ev1_valid;
  event_t      ev0, ev1;
  logic [7:0]  nb_inc;
  logic        enter_done;
  logic        end_issued;

  assign b      = octet.data_byte;
  assign eop    = octet.end_of_packet;
  assign nb_inc = (held_nb < 8'd255) ? held_nb + 8'd1 : held_nb;

  // Compute next state and events for the byte
  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    counts_next     = counts;
    cur_sec_next    = cur_sec;
    items_next      = items;
    label_left_next = label_left;
    rdata_left_next = rdata_left;
    shift_next      = shift;
    held_ident_next = held_ident;
    held_flags_next = held_flags;
    held_type_next  = held_type;
    held_class_next = held_class;
    held_nb_next    = held_nb;
    held_comp_next  = held_comp;
    seek_go         = 1'b0;
    seek_sec        = cur_sec;
    seek_items      = items - 16'd1;
    stop            = 1'b0;
    done            = 1'b0;
    ev0_valid       = 1'b0;
    ev0             = '0;
    ev1_valid       = 1'b0;
    ev1             = '0;

    case (phase)
      PH_HEADER: begin
        shift_next = {shift[23:0], b};
        case (idx)
          4'd1:    held_ident_next = shift_next[15:0];
          4'd3:    held_flags_next = shift_next[15:0];
          4'd5:    counts_next[0]  = shift_next[15:0];
          4'd7:    counts_next[1]  = shift_next[15:0];
          4'd9:    counts_next[2]  = shift_next[15:0];
          4'd11:   counts_next[3]  = shift_next[15:0];
          default: ;
        endcase
        if (idx >= 4'd11) begin
          idx_next          = 4'd0;
          ev0_valid         = 1'b1;
          ev0.event_kind    = EV_HEADER;
          ev0.message_ident = held_ident;
          ev0.header_flags  = held_flags;
          seek_go           = 1'b1;
          seek_sec          = 2'd0;
          seek_items        = counts_next[0];
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_NAME: begin
        held_nb_next = nb_inc;
        if (b == 8'd0) begin
          phase_next = PH_FIXED;
          idx_next   = 4'd0;
        end else if ((b & PTR_MASK) != 8'd0) begin
          held_comp_next = 1'b1;
          phase_next     = PH_PTR2;
        end else begin
          label_left_next = b;
          phase_next      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        held_nb_next    = nb_inc;
        label_left_next = label_left - 8'd1;
        if (label_left_next == 8'd0) begin
          phase_next = PH_NAME;
        end
      end
      PH_PTR2: begin
        held_nb_next = nb_inc;
        phase_next   = PH_FIXED;
        idx_next     = 4'd0;
      end
      PH_FIXED: begin
        if (idx < 4'd8) begin
          shift_next = {shift[23:0], b};
        end else begin
          rdata_left_next = {rdata_left[7:0], b};
        end
        if (idx == 4'd1) begin
          held_type_next = shift_next[15:0];
        end
        // Class done: a question completes here
        if (idx == 4'd3) begin
          held_class_next = shift_next[15:0];
          if (cur_sec == 2'd0) begin
            ev0_valid           = 1'b1;
            ev0.event_kind      = EV_QUESTION;
            ev0.rr_type         = held_type;
            ev0.record_class    = held_class_next;
            ev0.name_bytes      = held_nb;
            ev0.name_compressed = held_comp;
            seek_go             = 1'b1;
            stop                = 1'b1;
          end
        end
        // Data length done: a record completes here
        if (!stop && idx == 4'd9) begin
          ev0_valid           = 1'b1;
          ev0.event_kind      = EV_RECORD;
          ev0.section         = cur_sec;
          ev0.rr_type         = held_type;
          ev0.record_class    = held_class;
          ev0.time_to_live    = shift_next;
          ev0.rdata_length    = rdata_left_next;
          ev0.name_bytes      = held_nb;
          ev0.name_compressed = held_comp;
          if (rdata_left_next == 16'd0) begin
            seek_go = 1'b1;
          end else begin
            phase_next = PH_RDATA;
          end
          stop = 1'b1;
        end
        if (!stop) begin
          idx_next = idx + 4'd1;
        end
      end
      PH_RDATA: begin
        rdata_left_next = rdata_left - 16'd1;
        if (rdata_left_next == 16'd0) begin
          seek_go = 1'b1;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    // Advance to the next item or finish the message
    sk = seek(seek_sec, seek_items, counts_next);
    if (seek_go) begin
      cur_sec_next = sk.sec;
      items_next   = sk.items;
      if (sk.done) begin
        phase_next = PH_DONE;
        done       = 1'b1;
      end else begin
        phase_next     = PH_NAME;
        idx_next       = 4'd0;
        held_nb_next   = 8'd0;
        held_comp_next = 1'b0;
      end
    end

    if (done) begin
      ev1_valid      = 1'b1;
      ev1.event_kind = EV_END;
      ev1.last       = 1'b1;
    end

    // Close the message on packet end
    if (eop) begin
      if (!done && phase_next != PH_DONE) begin
        ev1_valid      = 1'b1;
        ev1.event_kind = EV_TRUNCATED;
        ev1.section    = (phase_next == PH_HEADER) ? 2'd0 : cur_sec_next;
        ev1.last       = 1'b1;
      end
      phase_next      = PH_HEADER;
      idx_next        = 4'd0;
      cur_sec_next    = 2'd0;
      items_next      = 16'd0;
      label_left_next = 8'd0;
      rdata_left_next = 16'd0;
    end
  end

  // Pack events into the queue slots in order
  always_comb begin
    push.first  = take && (ev0_valid || ev1_valid);
    push.second = take && ev0_valid && ev1_valid;
    slot0       = ev0_valid ? ev0 : ev1;
    slot1       = ev1;
  end

  // Hold state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      idx        <= '0;
      counts     <= '0;
      cur_sec    <= '0;
      items      <= '0;
      label_left <= '0;
      rdata_left <= '0;
      shift      <= '0;
      held_ident <= '0;
      held_flags <= '0;
      held_type  <= '0;
      held_class <= '0;
      held_nb    <= '0;
      held_comp  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      idx        <= idx_next;
      counts     <= counts_next;
      cur_sec    <= cur_sec_next;
      items      <= items_next;
      label_left <= label_left_next;
      rdata_left <= rdata_left_next;
      shift      <= shift_next;
      held_ident <= held_ident_next;
      held_flags <= held_flags_next;
      held_type  <= held_type_next;
      held_class <= held_class_next;
      held_nb    <= held_nb_next;
      held_comp  <= held_comp_next;
    end
  end

  // Message completion seen this cycle, and an end word pushed for it
  assign enter_done = take && phase_next == PH_DONE && phase != PH_DONE && !eop;
  assign end_issued = push.first && (slot0.event_kind == EV_END || slot1.event_kind == EV_END);

  `DRP_ASSERT(a_second_needs_first, push.second |-> push.first, "second push without first")
  `DRP_ASSERT(a_second_is_final, push.second |-> slot1.last, "second event is not final")
  `DRP_ASSERT(a_eop_restarts, (take && eop) |=> (phase == PH_HEADER && idx == 4'd0), "no rearm")
  `DRP_ASSERT(a_done_has_end, enter_done |-> end_issued, "message done without end event")

endmodule

// ===== src/drp_event_queue.sv =====
// ----------------------------------------------------------------------------
// drp_event_queue
// Small event queue: takes up to two events per cycle, hands out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drp_event_queue #(
  parameter int DEPTH = drp_pkg::EVQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  drp_pkg::push_t  push,
  input  drp_pkg::event_t slot0,
  input  drp_pkg::event_t slot1,
  output logic            room,
  output logic            evt_valid,
  input  logic            evt_ready,
  output drp_pkg::event_t evt
);
  import drp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  event_t          entries [DEPTH];
  logic [PW-1:0]   head, tail, tail_second;
  logic [CW-1:0]   count, count_next;
  logic            pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop         = evt_valid && evt_ready;
  assign evt_valid   = (count != '0);
  assign evt         = entries[head];
  assign room        = (count <= CW'(DEPTH - 2));
  assign tail_second = bump(tail);
  assign count_next  = count + CW'(push.first) + CW'(push.second) - CW'(pop);

  // Store pushed events
  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[tail] <= slot0;
    end
    if (push.second) begin
      entries[tail_second] <= slot1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= bump(head);
      end
      if (push.second) begin
        tail <= bump(tail_second);
      end else if (push.first) begin
        tail <= tail_second;
      end
    end
  end

  `DRP_ASSERT(a_count_bound, count <= CW'(DEPTH), "queue count beyond depth")
  `DRP_ASSERT_NEVER(a_push_overflow, push.first && !room, "push with no room")
  `DRP_ASSERT(a_pop_only, (pop && !push.first) |=> (count == $past(count) - CW'(1)), "pop count slip")

endmodule

// ===== src/dns_response_record_parser_core.sv =====
// ----------------------------------------------------------------------------
// dns_response_record_parser_core
// Streaming DNS response parser: header, question and record events.
// ----------------------------------------------------------------------------
// Events of an accepted byte enter the event queue and are offered on evt
// after older events. One byte per cycle while octet_ready is high; a byte
// causing two events (end or truncation after another event) fills two
// entries. octet_ready falls while the queue has under two free entries.
// Reset (rst, synchronous): parser returns to the header phase, queue empties.

module dns_response_record_parser_core #(
  parameter int QUEUE_DEPTH = drp_pkg::EVQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            octet_valid,
  output logic            octet_ready,
  input  drp_pkg::octet_t octet,
  output logic            evt_valid,
  input  logic            evt_ready,
  output drp_pkg::event_t evt
);
  import drp_pkg::*;

  push_t  push;
  event_t slot0, slot1;
  logic   room;
  logic   take;

  assign octet_ready = room;
  assign take        = octet_valid && octet_ready;

  // Parse state and event generation
  drp_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .octet (octet),
    .push  (push),
    .slot0 (slot0),
    .slot1 (slot1)
  );

  // Event buffering toward the output
  drp_event_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot0     (slot0),
    .slot1     (slot1),
    .room      (room),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

endmodule

// ===== dv/dns_response_record_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// dns_response_record_parser_core_tb
// Drives DNS response bytes into the parser core, one word per handshake,
// and checks every emitted event against a byte-level parse model kept in
// the bench or, for typed table rows, against hand-built events. A short
// table of hand-built packets covers header extremes, early packet end and
// empty sections. Random packets follow: mostly well-formed messages with
// random names, pointers, records and RDATA, some truncated, padded or pure
// noise. Random idle and stall bursts are applied on both channels.
// ----------------------------------------------------------------------------
module dns_response_record_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RANDOM_OCTETS  = 1100;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LIMIT_CYCLES   = 1_200_000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIR_ROWS       = 25;

  // Section codes
  localparam logic [1:0] SEC_QUESTION   = 2'd0;
  localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

  localparam event_t NO_EVENT = '0;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_NAME,
    ST_LABEL,
    ST_PTR_LOW,
    ST_FIXED,
    ST_RDATA,
    ST_DONE
  } parse_state_e;

  typedef struct packed {
    octet_t     word;
    logic [1:0] n_typed;
    event_t     first_ev;
    event_t     second_ev;
  } directed_row_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   octet_valid;
  logic   octet_ready;
  octet_t octet;
  logic   evt_valid;
  logic   evt_ready;
  event_t evt;

  // Parse model state
  parse_state_e st         = ST_HEADER;
  logic [3:0]   byte_idx   = '0;
  logic [15:0]  sec_count [4] = '{default: '0};
  logic [1:0]   cur_sec    = '0;
  logic [15:0]  items_left = '0;
  logic [7:0]   label_left = '0;
  logic [15:0]  rdata_left = '0;
  logic [31:0]  shift_reg  = '0;
  logic [15:0]  ident_q    = '0;
  logic [15:0]  flags_q    = '0;
  logic [15:0]  type_q     = '0;
  logic [15:0]  class_q    = '0;
  logic [7:0]   owner_len  = '0;
  logic         name_ptr   = 1'b0;

  event_t        byte_events [$];
  event_t        awaited_events [$];
  octet_t        msg_stream [$];
  directed_row_t dir_rows [DIR_ROWS];

  int fail_count    = 0;
  int kind_seen [8] = '{default: 0};
  int octets_sent   = 0;
  int packets_sent  = 0;
  int idle_pct      = 10;
  int stall_pct     = 10;
  int stall_left    = 0;
  bit tail_quiet    = 1'b0;

  dns_response_record_parser_core DUT (
    .clk         (clk),
    .rst         (rst),
    .octet_valid (octet_valid),
    .octet_ready (octet_ready),
    .octet       (octet),
    .evt_valid   (evt_valid),
    .evt_ready   (evt_ready),
    .evt         (evt)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic event_t make_event(
    input logic [2:0] kind, input logic [1:0] sec,
    input logic [15:0] ident, input logic [15:0] flags,
    input logic [15:0] typ, input logic [15:0] cls,
    input logic [31:0] ttl, input logic [15:0] rdlen,
    input logic [7:0] nb, input logic comp, input logic last);
    event_t e;
    e.event_kind      = kind;
    e.section         = sec;
    e.message_ident   = ident;
    e.header_flags    = flags;
    e.rr_type         = typ;
    e.record_class    = cls;
    e.time_to_live    = ttl;
    e.rdata_length    = rdlen;
    e.name_bytes      = nb;
    e.name_compressed = comp;
    e.last            = last;
    return e;
  endfunction

  function automatic string fmt_event(input event_t e);
    return $sformatf("kind=%0d sec=%0d id=%h fl=%h ty=%h cl=%h ttl=%h len=%h nb=%0d c=%b last=%b",
                     e.event_kind, e.section, e.message_ident, e.header_flags,
                     e.rr_type, e.record_class, e.time_to_live,
                     e.rdata_length, e.name_bytes, e.name_compressed, e.last);
  endfunction

  // Step past empty sections; return 1 once the message is complete
  function automatic bit next_item(input bit consume);
    if (consume) items_left = items_left - 16'd1;
    while (items_left == 16'd0) begin
      if (cur_sec == SEC_ADDITIONAL) begin
        st = ST_DONE;
        return 1'b1;
      end
      cur_sec    = cur_sec + 2'd1;
      items_left = sec_count[cur_sec];
    end
    st        = ST_NAME;
    byte_idx  = '0;
    owner_len = '0;
    name_ptr  = 1'b0;
    return 1'b0;
  endfunction

  // Advance the parse model by one byte and collect the events it causes
  task automatic parse_octet(input logic [7:0] b, input logic eop);
    bit         done;
    logic [1:0] sec;
    done = 1'b0;
    sec  = cur_sec;
    byte_events.delete();
    case (st)
      ST_HEADER: begin
        shift_reg = {shift_reg[23:0], b};
        case (byte_idx)
          4'd1:  ident_q      = shift_reg[15:0];
          4'd3:  flags_q      = shift_reg[15:0];
          4'd5:  sec_count[0] = shift_reg[15:0];
          4'd7:  sec_count[1] = shift_reg[15:0];
          4'd9:  sec_count[2] = shift_reg[15:0];
          4'd11: sec_count[3] = shift_reg[15:0];
          default: ;
        endcase
        if (byte_idx >= 4'd11) begin
          byte_idx = '0;
          byte_events.push_back(make_event(EV_HEADER, '0, ident_q, flags_q,
                                           '0, '0, '0, '0, '0, 1'b0, 1'b0));
          cur_sec    = SEC_QUESTION;
          items_left = sec_count[0];
          done       = next_item(1'b0);
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      ST_NAME: begin
        if (owner_len != 8'd255) owner_len = owner_len + 8'd1;
        if (b == 8'd0) begin
          st       = ST_FIXED;
          byte_idx = '0;
        end else if ((b & PTR_MASK) != 8'd0) begin
          name_ptr = 1'b1;
          st       = ST_PTR_LOW;
        end else begin
          label_left = b;
          st         = ST_LABEL;
        end
      end
      ST_LABEL: begin
        if (owner_len != 8'd255) owner_len = owner_len + 8'd1;
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) st = ST_NAME;
      end
      ST_PTR_LOW: begin
        if (owner_len != 8'd255) owner_len = owner_len + 8'd1;
        st       = ST_FIXED;
        byte_idx = '0;
      end
      ST_FIXED: begin
        if (byte_idx < 4'd8) shift_reg = {shift_reg[23:0], b};
        else rdata_left = {rdata_left[7:0], b};
        if (byte_idx == 4'd1) type_q = shift_reg[15:0];
        if (byte_idx == 4'd3) class_q = shift_reg[15:0];
        if (byte_idx == 4'd3 && sec == SEC_QUESTION) begin
          byte_events.push_back(make_event(EV_QUESTION, SEC_QUESTION, '0, '0, type_q,
                                           class_q, '0, '0, owner_len, name_ptr, 1'b0));
          done = next_item(1'b1);
        end else if (byte_idx == 4'd9) begin
          byte_events.push_back(make_event(EV_RECORD, sec, '0, '0, type_q, class_q,
                                           shift_reg, rdata_left, owner_len, name_ptr,
                                           1'b0));
          if (rdata_left == 16'd0) done = next_item(1'b1);
          else st = ST_RDATA;
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      ST_RDATA: begin
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0) done = next_item(1'b1);
      end
      default: st = ST_DONE;
    endcase

    if (done)
      byte_events.push_back(make_event(EV_END, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));

    // End of packet: flag an unfinished message, then rearm for the next one
    if (eop) begin
      if (!done && st != ST_DONE)
        byte_events.push_back(make_event(EV_TRUNCATED, (st == ST_HEADER) ? 2'd0 : cur_sec,
                                         '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
      st         = ST_HEADER;
      byte_idx   = '0;
      cur_sec    = SEC_QUESTION;
      items_left = '0;
      label_left = '0;
      rdata_left = '0;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  // Compare one received word with the oldest awaited event
  task automatic check_event(input event_t got);
    event_t want;
    string  bad;
    if (awaited_events.size() == 0) begin
      note_failure($sformatf("unexpected word: %s", fmt_event(got)));
      return;
    end
    want = awaited_events.pop_front();
    bad  = "";
    if (got.event_kind      !== want.event_kind)      bad = {bad, " event_kind"};
    if (got.section         !== want.section)         bad = {bad, " section"};
    if (got.message_ident   !== want.message_ident)   bad = {bad, " message_ident"};
    if (got.header_flags    !== want.header_flags)    bad = {bad, " header_flags"};
    if (got.rr_type         !== want.rr_type)         bad = {bad, " rr_type"};
    if (got.record_class    !== want.record_class)    bad = {bad, " record_class"};
    if (got.time_to_live    !== want.time_to_live)    bad = {bad, " time_to_live"};
    if (got.rdata_length    !== want.rdata_length)    bad = {bad, " rdata_length"};
    if (got.name_bytes      !== want.name_bytes)      bad = {bad, " name_bytes"};
    if (got.name_compressed !== want.name_compressed) bad = {bad, " name_compressed"};
    if (got.last            !== want.last)            bad = {bad, " last"};
    if (bad != "")
      note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                             bad, fmt_event(want), fmt_event(got)));
  endtask

  // Offer one word, wait for it to be taken, then record what it should cause
  task automatic send_octet(input octet_t o, input logic [1:0] n_typed,
                            input event_t first_ev, input event_t second_ev);
    if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
      octet_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    octet_valid = 1'b1;
    octet       = o;
    @(posedge clk);
    while (!octet_ready) @(posedge clk);
    parse_octet(o.data_byte, o.end_of_packet);
    if (n_typed == 2'd0) begin
      foreach (byte_events[k]) awaited_events.push_back(byte_events[k]);
    end else begin
      awaited_events.push_back(first_ev);
      if (n_typed == 2'd2) awaited_events.push_back(second_ev);
    end
    octets_sent++;
    if (o.end_of_packet) packets_sent++;
    @(negedge clk);
  endtask

  // Build one random packet into the stream; return the bytes that matter
  task automatic add_message(output int useful);
    logic [7:0]  body [$];
    logic [15:0] counts [4];
    logic [15:0] rdlen;
    int          n_lab;
    int          lab_len;
    int          cut;
    int          extra;
    bit          long_name;
    bit          chop;
    octet_t      o;
    extra = 0;
    if ($urandom_range(0, 99) < 8) begin
      // noise
      repeat ($urandom_range(1, 40)) body.push_back(8'($urandom));
    end else begin
      chop = ($urandom_range(0, 6) == 0);
      for (int s = 0; s < 4; s++) begin
        counts[s] = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        if (counts[s] > 16'd3) chop = 1'b1;
      end
      repeat (4) body.push_back(8'($urandom));
      for (int s = 0; s < 4; s++) begin
        body.push_back(counts[s][15:8]);
        body.push_back(counts[s][7:0]);
      end
      for (int s = 0; s < 4; s++) begin
        for (int i = 0; i < counts[s] && i < 3; i++) begin
          long_name = ($urandom_range(0, 39) == 0);
          n_lab     = long_name ? 5 : $urandom_range(0, 3);
          repeat (n_lab) begin
            if (long_name) lab_len = $urandom_range(50, 63);
            else if ($urandom_range(0, 9) == 0) lab_len = $urandom_range(1, 63);
            else lab_len = $urandom_range(1, 6);
            body.push_back(8'(lab_len));
            repeat (lab_len) body.push_back(8'($urandom));
          end
          // terminate with root label or a pointer of any marker form
          if ($urandom_range(0, 1)) begin
            body.push_back(8'd0);
          end else begin
            body.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
            body.push_back(8'($urandom));
          end
          repeat (4) body.push_back(8'($urandom));
          if (s != 0) begin
            repeat (4) body.push_back(8'($urandom));
            rdlen = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(100, 400))
                                                 : 16'($urandom_range(0, 6));
            body.push_back(rdlen[15:8]);
            body.push_back(rdlen[7:0]);
            repeat (rdlen) body.push_back(8'($urandom));
          end
        end
      end
      if (chop) begin
        cut = $urandom_range(1, body.size() - 1);
        while (body.size() > cut) void'(body.pop_back());
      end else if ($urandom_range(0, 5) == 0) begin
        extra = $urandom_range(1, 3);
        repeat (extra) body.push_back(8'($urandom));
      end
    end
    useful = body.size() - extra;
    foreach (body[k]) begin
      o.data_byte     = body[k];
      o.end_of_packet = (k == body.size() - 1);
      msg_stream.push_back(o);
    end
  endtask

  // Result side: random stall bursts, none in the tail
  initial begin
    evt_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (tail_quiet) begin
        evt_ready = 1'b1;
      end else if (stall_left > 0) begin
        evt_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        evt_ready  = 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        evt_ready = 1'b1;
      end
    end
  end

  // Check every accepted event word
  always @(posedge clk) begin
    if (!rst && evt_valid && evt_ready) begin
      kind_seen[evt.event_kind]++;
      check_event(evt);
    end
  end

  initial begin
    event_t hdr_max_id;
    event_t hdr_max_cnt;
    event_t end_ev;
    event_t trunc_q;
    int     useful;
    int     useful_total;
    int     tail_start;

    rst         = 1'b1;
    octet_valid = 1'b0;
    octet       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    hdr_max_id  = make_event(EV_HEADER, '0, 16'hffff, 16'h0000, '0, '0, '0, '0, '0,
                             1'b0, 1'b0);
    hdr_max_cnt = make_event(EV_HEADER, '0, 16'h0000, 16'hffff, '0, '0, '0, '0, '0,
                             1'b0, 1'b0);
    end_ev      = make_event(EV_END, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    trunc_q     = make_event(EV_TRUNCATED, SEC_QUESTION, '0, '0, '0, '0, '0, '0, '0,
                             1'b0, 1'b1);

    dir_rows = '{
      // lone byte closes the packet inside the header
      '{'{8'hab, 1'b1}, 2'd1, trunc_q, NO_EVENT},
      // all sections empty: header and end on the twelfth byte
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b1}, 2'd2, hdr_max_id, end_ev},
      // all counts at maximum, packet ends right after the header
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'h00, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b0}, 2'd0, NO_EVENT, NO_EVENT},
      '{'{8'hff, 1'b1}, 2'd2, hdr_max_cnt, trunc_q}
    };

    foreach (dir_rows[k])
      send_octet(dir_rows[k].word, dir_rows[k].n_typed, dir_rows[k].first_ev,
                 dir_rows[k].second_ev);

    useful_total = 0;
    while (useful_total < RANDOM_OCTETS) begin
      add_message(useful);
      useful_total += useful;
    end

    // Vary idle and stall pressure per packet; drop both for the tail
    tail_start = msg_stream.size() * 17 / 20;
    foreach (msg_stream[k]) begin
      if (k == tail_start) tail_quiet = 1'b1;
      if (!tail_quiet && (k == 0 || msg_stream[k - 1].end_of_packet)) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 4;
          default: idle_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 4;
          default: stall_pct = 25;
        endcase
      end
      send_octet(msg_stream[k], 2'd0, NO_EVENT, NO_EVENT);
    end
    octet_valid = 1'b0;

    // Drain, then watch for stray words
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d packets (%0d from the directed table).",
             octets_sent, packets_sent, DIR_ROWS);
    $display("Events checked: header %0d, question %0d, record %0d, truncated %0d, end %0d.",
             kind_seen[EV_HEADER], kind_seen[EV_QUESTION], kind_seen[EV_RECORD],
             kind_seen[EV_TRUNCATED], kind_seen[EV_END]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures detected.", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timeout with %0d events still awaited.", awaited_events.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
